// ===== hw/rtl/csra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csra_pkg
// Shared types and constants of the contiguous slot run allocator.
// ----------------------------------------------------------------------------
package csra_pkg;

    // number of page slots, a multiple of DIGIT_W
    localparam int SLOT_COUNT = 512;
    // slots held in one bitmap row, all scanned together
    localparam int DIGIT_W    = 8;
    localparam int DIG_IW     = $clog2(DIGIT_W);
    localparam int ROWS       = SLOT_COUNT / DIGIT_W;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    // slot index arithmetic, wide enough for start plus count
    localparam int WIDE_W     = 13;

    localparam int OP_W    = 2;
    localparam int CNT_W   = 10;
    localparam int ADDR_W  = 48;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 9;
    localparam int PAGE_SH = 12;
    localparam int BASE_BIT = 39;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCK   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNLOCK = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_RUN     = 3'd1;
    localparam logic [STAT_W-1:0] ST_LOCKED     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_TOP    = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_SECOND = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_THIRD  = 3'd5;
    localparam logic [STAT_W-1:0] ST_PAST_END   = 3'd6;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC  = 3'd7;

    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [WIDE_W-1:0]  t_wide;

    typedef struct packed {
        logic   en;
        t_row   row;
        t_digit data;
    } t_bm_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_ASCAN,
        S_RD,
        S_WR,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/csra_bitmap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csra_bitmap
// Slot bitmap memory, one row of DIGIT_W slots per word, registered read.
// A per-row valid flag cleared by reset makes unwritten rows read as free.
// ----------------------------------------------------------------------------
module csra_bitmap (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csra_pkg::t_row  i_rd_row,
    input  csra_pkg::t_bm_wr i_wr,
    output csra_pkg::t_digit o_rd_data
);
    import csra_pkg::*;

    t_digit           r_mem [ROWS];
    logic [ROWS-1:0]  r_vld;
    t_digit           r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.row] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.row] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hw/rtl/contiguous_slot_run_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_run_allocator_top
// First-fit contiguous run allocator over a bitmap of page slots.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) takes one command beat: operation, slot
// count and region address. Output channel (o_valid / i_ready) returns one
// beat per command: status and run address (zero unless allocate succeeds).
// One command is in flight at a time; o_ready is high only while idle.
// The bitmap is held as ROWS rows of DIGIT_W slots. An allocate scans rows
// lowest first, one row per cycle, up to ROWS = 64 rows; then allocate and
// free read-modify-write each row of the run in turn, reading it in S_RD and
// writing it in S_WR. A finished result sits in the output register; if the
// receiver stalls, the next command is still accepted and runs until its own
// result waits for the output register to drain. Reset frees every slot (the
// per-row valid flags are all cleared at once) and clears the lock; no
// clearing pass.
// ----------------------------------------------------------------------------
module contiguous_slot_run_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [csra_pkg::OP_W-1:0]     i_operation,
    input  logic [csra_pkg::CNT_W-1:0]    i_slot_count,
    input  logic [csra_pkg::ADDR_W-1:0]   i_region_address,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [csra_pkg::STAT_W-1:0]   o_status,
    output logic [csra_pkg::ADDR_W-1:0]   o_run_address
);
    import csra_pkg::*;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_locked, n_locked;
    t_row                r_row, n_row;
    logic [CNT_W-1:0]    r_run, n_run;
    t_wide               r_first, n_first;
    t_wide               r_last, n_last;
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_o_valid;
    logic [STAT_W-1:0]   r_o_status;
    logic [ADDR_W-1:0]   r_o_addr;

    t_row                rd_row;
    t_bm_wr              bm_wr;
    t_digit              rd_data;

    // scan of one row
    logic [CNT_W-1:0]    run_c;
    logic                hit;
    logic [DIG_IW-1:0]   hit_j;
    t_wide               hit_end;
    t_wide               hit_first;

    // read-modify-write of one row
    t_digit              in_rng;
    t_digit              clr_mask;
    logic                miss;
    t_wide               slot_idx;
    logic                last_row;

    logic                accept;
    logic                out_load;
    logic [IDX_W-1:0]    f_start;
    t_wide               f_start_w;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign f_start = r_addr[PAGE_SH+IDX_W-1:PAGE_SH];
    assign f_start_w = WIDE_W'(f_start);

    csra_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_row  (rd_row),
        .i_wr      (bm_wr),
        .o_rd_data (rd_data)
    );

    // run counting across one row, lowest slot first
    always_comb begin
        run_c = r_run;
        hit   = 1'b0;
        hit_j = '0;
        for (int j = 0; j < DIGIT_W; j++) begin
            if (!hit) begin
                if (rd_data[j]) begin
                    run_c = '0;
                end else begin
                    run_c = run_c + CNT_W'(1);
                end
                if (run_c == r_count) begin
                    hit   = 1'b1;
                    hit_j = DIG_IW'(j);
                end
            end
        end
        hit_end   = WIDE_W'({r_row, hit_j});
        hit_first = hit_end + WIDE_W'(1) - WIDE_W'(r_count);
    end

    // slots of the current row inside [first, last], and the first free one
    always_comb begin
        in_rng   = '0;
        clr_mask = '0;
        miss     = 1'b0;
        slot_idx = '0;
        for (int j = 0; j < DIGIT_W; j++) begin
            slot_idx  = WIDE_W'({r_row, DIG_IW'(j)});
            in_rng[j] = (slot_idx >= r_first) && (slot_idx <= r_last);
            if (in_rng[j] && !miss) begin
                if (!rd_data[j]) begin
                    miss = 1'b1;
                end else begin
                    clr_mask[j] = 1'b1;
                end
            end
        end
        last_row = (WIDE_W'(r_row) == (r_last >> DIG_IW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_locked <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_locked <= n_locked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_count <= i_slot_count;
            r_addr  <= i_region_address;
        end
        r_row        <= n_row;
        r_run        <= n_run;
        r_first      <= n_first;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
    end

    always_comb begin
        n_state      = r_state;
        n_locked     = r_locked;
        n_row        = r_row;
        n_run        = r_run;
        n_first      = r_first;
        n_last       = r_last;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        rd_row       = r_row;
        bm_wr.en     = 1'b0;
        bm_wr.row    = r_row;
        bm_wr.data   = rd_data;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res_status = ST_OK;
                n_res_addr   = '0;
                n_state      = S_DONE;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_count == '0) begin
                            n_res_status = ST_NO_RUN;
                        end else begin
                            rd_row  = '0;
                            n_row   = '0;
                            n_run   = '0;
                            n_state = S_ASCAN;
                        end
                    end
                    OP_FREE: begin
                        if (r_locked) begin
                            n_res_status = ST_LOCKED;
                        end else if (r_addr[ADDR_W-1:BASE_BIT] != IDX_W'(1)) begin
                            n_res_status = ST_BAD_TOP;
                        end else if (r_addr[BASE_BIT-1:BASE_BIT-IDX_W] != '0) begin
                            n_res_status = ST_BAD_SECOND;
                        end else if (r_addr[BASE_BIT-IDX_W-1:PAGE_SH+IDX_W] != '0) begin
                            n_res_status = ST_BAD_THIRD;
                        end else if (r_count == '0) begin
                            n_res_status = ST_OK;
                        end else if (f_start_w >= WIDE_W'(SLOT_COUNT)) begin
                            n_res_status = ST_PAST_END;
                        end else begin
                            n_first = f_start_w;
                            n_last  = f_start_w + WIDE_W'(r_count) - WIDE_W'(1);
                            n_row   = f_start_w[ROW_W+DIG_IW-1:DIG_IW];
                            n_state = S_RD;
                        end
                    end
                    OP_LOCK: begin
                        n_locked = 1'b1;
                    end
                    OP_UNLOCK: begin
                        n_locked = 1'b0;
                    end
                    default: begin
                        n_locked = r_locked;
                    end
                endcase
            end
            S_ASCAN: begin
                // rd_data holds row r_row, the next row is being fetched
                rd_row = r_row + ROW_W'(1);
                if (hit) begin
                    n_first = hit_first;
                    n_last  = hit_end;
                    n_row   = hit_first[ROW_W+DIG_IW-1:DIG_IW];
                    n_state = S_RD;
                end else if (r_row == ROW_W'(ROWS - 1)) begin
                    n_res_status = ST_NO_RUN;
                    n_res_addr   = '0;
                    n_state      = S_DONE;
                end else begin
                    n_row = r_row + ROW_W'(1);
                    n_run = run_c;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                bm_wr.en = 1'b1;
                n_state  = S_RD;
                n_row    = r_row + ROW_W'(1);
                if (r_op == OP_ALLOC) begin
                    bm_wr.data = rd_data | in_rng;
                    if (last_row) begin
                        n_res_status = ST_OK;
                        n_res_addr   = (ADDR_W'(r_first) << PAGE_SH)
                                       | (ADDR_W'(1) << BASE_BIT);
                        n_state      = S_DONE;
                    end
                end else begin
                    bm_wr.data = rd_data & ~clr_mask;
                    if (miss) begin
                        n_res_status = ST_NOT_ALLOC;
                        n_state      = S_DONE;
                    end else if (last_row) begin
                        n_res_status = ST_OK;
                        n_state      = S_DONE;
                    end else if (r_row == ROW_W'(ROWS - 1)) begin
                        n_res_status = ST_PAST_END;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register, loads when empty or draining this cycle
    assign out_load = (r_state == S_DONE) && (!r_o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_addr   <= r_res_addr;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_run_address = r_o_addr;

    a_wr_only_in_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bm_wr.en |-> (r_state == S_WR))
        else $error("bitmap written outside read-modify-write");

    a_accept_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DEC))
        else $error("accepted beat not decoded next cycle");

    a_run_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASCAN) |-> (r_run < r_count))
        else $error("run length passed requested count during scan");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_run_address == '0))
        else $error("failed beat carries a run address");

    a_addr_has_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_run_address != '0)) |-> o_run_address[BASE_BIT])
        else $error("run address missing region base bit");

endmodule

// ===== verif/contiguous_slot_run_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_run_allocator_checker
// Watches the command and response channels of the slot run allocator. It
// keeps its own slot bitmap and lock flag, works out the outcome of every
// accepted command beat, and compares each response beat, field by field,
// with the oldest outcome still awaited.
// ----------------------------------------------------------------------------
module contiguous_slot_run_allocator_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  logic [csra_pkg::OP_W-1:0]     i_operation,
    input  logic [csra_pkg::CNT_W-1:0]    i_slot_count,
    input  logic [csra_pkg::ADDR_W-1:0]   i_region_address,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [csra_pkg::STAT_W-1:0]   i_status,
    input  logic [csra_pkg::ADDR_W-1:0]   i_run_address,
    output int                            o_fail_count,
    output int                            o_pending
);
    import csra_pkg::*;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] run_address;
    } t_run_outcome;

    logic [SLOT_COUNT-1:0] slot_taken;
    logic                  free_blocked;
    t_run_outcome          awaited_outcomes[$];
    t_run_outcome          want;
    int                    mismatches = 0;

    task automatic compute_run_outcome(
        input  logic [OP_W-1:0]   op,
        input  logic [CNT_W-1:0]  count,
        input  logic [ADDR_W-1:0] addr,
        output t_run_outcome      res
    );
        int                run_len;
        int                first;
        int                start_idx;
        int                slot;
        bit                done;
        logic [ADDR_W-1:0] start_w;
        res.status      = ST_OK;
        res.run_address = '0;
        run_len         = 0;
        done            = 1'b0;
        case (op)
            OP_ALLOC: begin
                res.status = ST_NO_RUN;
                // first fit: lowest run of count clear bits
                for (int i = 0; i < SLOT_COUNT && count != 0 && !done; i++) begin
                    if (slot_taken[i]) begin
                        run_len = 0;
                    end else begin
                        run_len++;
                        if (run_len == count) begin
                            first = i + 1 - run_len;
                            for (int j = first; j <= i; j++) slot_taken[j] = 1'b1;
                            start_w                   = ADDR_W'(first);
                            res.run_address           = start_w << PAGE_SH;
                            res.run_address[BASE_BIT] = 1'b1;
                            res.status                = ST_OK;
                            done                      = 1'b1;
                        end
                    end
                end
            end
            OP_FREE: begin
                if (free_blocked) begin
                    res.status = ST_LOCKED;
                end else if (addr[PAGE_SH + 3*IDX_W +: IDX_W] != 1) begin
                    res.status = ST_BAD_TOP;
                end else if (addr[PAGE_SH + 2*IDX_W +: IDX_W] != 0) begin
                    res.status = ST_BAD_SECOND;
                end else if (addr[PAGE_SH + IDX_W +: IDX_W] != 0) begin
                    res.status = ST_BAD_THIRD;
                end else begin
                    start_idx = int'(addr[PAGE_SH +: IDX_W]);
                    // slots cleared ahead of a failure stay cleared
                    for (int i = 0; i < count && !done; i++) begin
                        slot = start_idx + i;
                        if (slot >= SLOT_COUNT) begin
                            res.status = ST_PAST_END;
                            done       = 1'b1;
                        end else if (!slot_taken[slot]) begin
                            res.status = ST_NOT_ALLOC;
                            done       = 1'b1;
                        end else begin
                            slot_taken[slot] = 1'b0;
                        end
                    end
                end
            end
            OP_LOCK: begin
                free_blocked = 1'b1;
            end
            OP_UNLOCK: begin
                free_blocked = 1'b0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_taken   = '0;
            free_blocked = 1'b0;
            awaited_outcomes.delete();
        end else begin
            // response side first, a beat accepted now cannot answer itself
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    mismatches++;
                    $display("%0t: response beat with nothing awaited, status %0d address %h",
                             $time, i_status, i_run_address);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (i_status !== want.status) begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_status);
                    end
                    if (i_run_address !== want.run_address) begin
                        mismatches++;
                        $display("%0t: run address mismatch, expected %h, actual %h",
                                 $time, want.run_address, i_run_address);
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                compute_run_outcome(i_operation, i_slot_count, i_region_address, want);
                awaited_outcomes.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_outcomes.size();
    end

endmodule

// ===== verif/contiguous_slot_run_allocator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_run_allocator_top_test
// Drives command beats into the slot run allocator: a directed opening over
// the corner cases, then a long random mix of allocates and of frees of runs
// that were really handed out. Both channels idle at random, and the
// response side holds off for long stretches so the block backs up.
// ----------------------------------------------------------------------------
module contiguous_slot_run_allocator_top_test;
    import csra_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [ADDR_W-1:0] base_addr;
        int                slots;
    } t_live_run;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [OP_W-1:0]   i_operation;
    logic [CNT_W-1:0]  i_slot_count;
    logic [ADDR_W-1:0] i_region_address;
    logic              o_valid;
    logic              i_ready;
    logic [STAT_W-1:0] o_status;
    logic [ADDR_W-1:0] o_run_address;

    int  fail_count;
    int  pending_results;
    int  cycle_count  = 0;
    int  sent_items   = 0;
    int  next_hold_at = 300;
    bit  src_steady   = 1'b0;
    bit  sink_steady  = 1'b0;
    bit  track_allocs = 1'b0;
    bit  lock_issued  = 1'b0;

    // size to record per accepted beat when an allocate comes back ok
    int        alloc_sizes[$];
    t_live_run live_runs[$];

    contiguous_slot_run_allocator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_slot_count     (i_slot_count),
        .i_region_address (i_region_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_run_address    (o_run_address)
    );

    contiguous_slot_run_allocator_checker run_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (i_valid),
        .i_cmd_ready      (o_ready),
        .i_operation      (i_operation),
        .i_slot_count     (i_slot_count),
        .i_region_address (i_region_address),
        .i_rsp_valid      (o_valid),
        .i_rsp_ready      (i_ready),
        .i_status         (o_status),
        .i_run_address    (o_run_address),
        .o_fail_count     (fail_count),
        .o_pending        (pending_results)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [ADDR_W-1:0] region_addr(input int start);
        logic [ADDR_W-1:0] a;
        a           = ADDR_W'(start);
        a           = a << PAGE_SH;
        a[BASE_BIT] = 1'b1;
        return a;
    endfunction

    task automatic send_command(
        input logic [OP_W-1:0]   op,
        input int                count,
        input logic [ADDR_W-1:0] addr
    );
        int gap;
        i_operation      <= op;
        i_slot_count     <= count[CNT_W-1:0];
        i_region_address <= addr;
        i_valid          <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        alloc_sizes.push_back((track_allocs && op == OP_ALLOC) ? count : 0);
        sent_items++;
        if (op == OP_LOCK) lock_issued = 1'b1;
        else if (op == OP_UNLOCK) lock_issued = 1'b0;
        gap = (!src_steady && $urandom_range(99) < 45) ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : response_sink
        int stall_left;
        int size_rec;
        stall_left = 0;
        i_ready   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready && alloc_sizes.size() > 0) begin
                size_rec = alloc_sizes.pop_front();
                if (o_status == ST_OK && size_rec > 0 && o_run_address != '0)
                    live_runs.push_back('{o_run_address, size_rec});
            end
            if ($urandom_range(199) == 0) sink_steady = !sink_steady;
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (sent_items >= next_hold_at) begin
                // long hold so the block fills and stalls the command side
                stall_left   = HOLD_CYCLES - 1;
                next_hold_at = next_hold_at + 500;
                i_ready     <= 1'b0;
            end else if (!sink_steady && $urandom_range(99) < 25) begin
                stall_left = pick_gap() - 1;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("contiguous_slot_run_allocator_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] rest_addr;
        logic [63:0]       noise_bits;
        t_live_run         pick;
        int                roll;
        int                count;
        int                k;
        int                free_share;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_operation      <= OP_ALLOC;
        i_slot_count     <= '0;
        i_region_address <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // allocate corner counts on an empty table
        send_command(OP_ALLOC, 0, '0);
        send_command(OP_ALLOC, SLOT_COUNT + 1, '0);
        send_command(OP_ALLOC, 1023, '1);
        send_command(OP_ALLOC, SLOT_COUNT, '0);
        send_command(OP_ALLOC, 1, '0);
        send_command(OP_FREE, SLOT_COUNT, region_addr(0));
        send_command(OP_ALLOC, 1, '0);
        send_command(OP_ALLOC, 3, '0);
        // lock blocks free but not allocate, repeats are harmless
        send_command(OP_LOCK, 0, '0);
        send_command(OP_LOCK, 1023, '1);
        send_command(OP_FREE, 1, region_addr(0));
        send_command(OP_ALLOC, 2, '0);
        send_command(OP_UNLOCK, 0, '0);
        send_command(OP_UNLOCK, 1023, '1);
        // index checks in order top, second, third
        send_command(OP_FREE, 1, '0);
        send_command(OP_FREE, 1, '1);
        addr = region_addr(0);
        addr[PAGE_SH + 2*IDX_W] = 1'b1;
        send_command(OP_FREE, 1, addr);
        addr = region_addr(0);
        addr[PAGE_SH + IDX_W] = 1'b1;
        send_command(OP_FREE, 1, addr);
        send_command(OP_FREE, 0, region_addr(100));
        // fill the tail, then a free running past the end keeps its clears
        send_command(OP_ALLOC, 506, '0);
        send_command(OP_FREE, 4, region_addr(510));
        send_command(OP_ALLOC, 2, '0);
        send_command(OP_FREE, 2, region_addr(0) | 48'hFFF);
        send_command(OP_FREE, 3, region_addr(1));
        send_command(OP_FREE, 510, region_addr(2));

        track_allocs = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99) == 0) src_steady = !src_steady;
            roll       = $urandom_range(99);
            free_share = (live_runs.size() > 24) ? 50 : 32;
            noise_bits = {$urandom, $urandom};
            if (roll < 8) begin
                case ($urandom_range(3))
                    0: begin
                        send_command(OP_W'($urandom_range(3)), $urandom_range(1023),
                                     noise_bits[ADDR_W-1:0]);
                    end
                    1: begin
                        addr = region_addr($urandom_range(SLOT_COUNT - 1));
                        addr[PAGE_SH-1:0] = noise_bits[PAGE_SH-1:0];
                        send_command(OP_FREE, $urandom_range(16), addr);
                    end
                    2: begin
                        addr = region_addr($urandom_range(SLOT_COUNT - 1));
                        addr[PAGE_SH + IDX_W +: 2*IDX_W] =
                            (2*IDX_W)'($urandom_range(1, (1 << (2*IDX_W)) - 1));
                        send_command(OP_FREE, $urandom_range(1, 8), addr);
                    end
                    default: begin
                        send_command(OP_ALLOC,
                                     ($urandom_range(1) != 0) ? 0
                                         : $urandom_range(SLOT_COUNT + 1, 1023),
                                     noise_bits[ADDR_W-1:0]);
                    end
                endcase
            end else if (roll < 11) begin
                send_command(OP_LOCK, $urandom_range(1023), noise_bits[ADDR_W-1:0]);
            end else if (roll < 16) begin
                send_command(OP_UNLOCK, $urandom_range(1023), noise_bits[ADDR_W-1:0]);
            end else if (roll < 16 + free_share && live_runs.size() > 0) begin
                k    = $urandom_range(live_runs.size() - 1);
                pick = live_runs[k];
                addr = pick.base_addr;
                if ($urandom_range(1) != 0) addr[PAGE_SH-1:0] = noise_bits[PAGE_SH-1:0];
                roll  = $urandom_range(99);
                count = pick.slots;
                if (roll >= 90) count = pick.slots + $urandom_range(1, 4);
                else if (roll >= 75 && pick.slots > 1) count = $urandom_range(1, pick.slots - 1);
                // a locked free changes nothing, so the run stays live
                if (!lock_issued) begin
                    live_runs.delete(k);
                    if (count < pick.slots) begin
                        rest_addr = ADDR_W'(count);
                        rest_addr = pick.base_addr + (rest_addr << PAGE_SH);
                        live_runs.push_back('{rest_addr, pick.slots - count});
                    end
                end
                send_command(OP_FREE, count, addr);
            end else begin
                roll = $urandom_range(99);
                if (roll < 70) count = $urandom_range(1, 8);
                else if (roll < 90) count = $urandom_range(9, 64);
                else if (roll < 97) count = $urandom_range(65, 256);
                else count = $urandom_range(257, SLOT_COUNT);
                send_command(OP_ALLOC, count, noise_bits[ADDR_W-1:0]);
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("contiguous_slot_run_allocator_top regression: pass");
        end else begin
            $display("contiguous_slot_run_allocator_top regression: fail");
        end
        $finish;
    end

endmodule
